// File: hdl/idpa_pkg.sv
package idpa_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int ID_W       = 8;
  localparam int CNT_W      = 9;
  localparam int MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_GET     = 2'd0,
    MODE_CHECK   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

// File: hdl/idpa_if.sv
interface idpa_req_if;
  import idpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   req_id;

  modport source (output valid, output mode, output req_id, input ready);
  modport sink   (input valid, input mode, input req_id, output ready);
endinterface

interface idpa_rsp_if;
  import idpa_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  logic            ok;

  modport source (output valid, output granted_id, output ok, input ready);
  modport sink   (input valid, input granted_id, input ok, output ready);
endinterface

// File: hdl/id_pool_allocator.sv
// ID pool allocator: hands out IDs 0..capacity-1 from a free stack, answers
// free/taken checks and takes IDs back. Each request produces exactly one
// response (get: granted_id and ok; check: ok when in range and free;
// release: ok when the ID was in range and taken). The top of the free stack
// is read from its synchronous RAM at the transfer edge; the commit, which
// waits while an earlier response is not yet taken, then updates the stack,
// bitmap and count and loads the result register that drives the response.
// The controller takes no new request until that commit, so each request is
// finished before the next one transfers. The result register lets the next
// request transfer while a response is still waiting. Writing capacity
// (saturated at 256) reinitializes the pool in that same cycle; there is no
// clearing pass after reset.
module id_pool_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [idpa_pkg::CNT_W-1:0] cfg_wdata,
  idpa_req_if.sink                   req,
  idpa_rsp_if.source                 rsp
);
  import idpa_pkg::*;

  cmd_t cmd;

  idpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  idpa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .mode       (req.mode),
    .req_id     (req.req_id),
    .granted_id (rsp.granted_id),
    .ok         (rsp.ok)
  );

endmodule

// File: hdl/idpa_ctrl.sv
module idpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output idpa_pkg::cmd_t cmd
);
  import idpa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/idpa_dp.sv
module idpa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [idpa_pkg::CNT_W-1:0]   cfg_wdata,
  input  idpa_pkg::cmd_t               cmd,
  input  logic [idpa_pkg::MODE_W-1:0]  mode,
  input  logic [idpa_pkg::ID_W-1:0]    req_id,
  output logic [idpa_pkg::ID_W-1:0]    granted_id,
  output logic                         ok
);
  import idpa_pkg::*;

  logic [CNT_W-1:0]      capacity;
  logic [CNT_W-1:0]      used_count;
  logic [POOL_DEPTH-1:0] avail;
  logic [POOL_DEPTH-1:0] stack_vld;
  logic [ID_W-1:0]       stack_mem [POOL_DEPTH];
  logic [ID_W-1:0]       rd_data;
  logic                  rd_vld;
  logic [MODE_W-1:0]     mode_q;
  logic [ID_W-1:0]       id_q;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] used_m1;
  logic [ID_W-1:0]  top_id;
  logic [ID_W-1:0]  rel_addr;
  logic [ID_W-1:0]  rd_addr;
  logic             id_in;
  logic             avail_id;
  logic             do_get;
  logic             do_rel;
  logic             res_ok;
  logic [ID_W-1:0]  res_id;

  // Entries never pushed since init read as their own index.
  assign eff_cap  = (capacity > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : capacity;
  assign used_m1  = used_count - CNT_W'(1);
  assign rel_addr = used_m1[ID_W-1:0];
  assign rd_addr  = used_count[ID_W-1:0];
  assign top_id   = rd_vld ? rd_data : used_count[ID_W-1:0];
  assign id_in    = ({1'b0, id_q} < eff_cap);
  assign avail_id = avail[id_q];

  always_comb begin
    do_get = 1'b0;
    do_rel = 1'b0;
    res_ok = 1'b0;
    res_id = '0;
    unique case (mode_t'(mode_q))
      MODE_GET: begin
        if (used_count < eff_cap) begin
          do_get = 1'b1;
          res_ok = 1'b1;
          res_id = top_id;
        end
      end
      MODE_CHECK: begin
        res_ok = id_in && avail_id;
      end
      MODE_RELEASE: begin
        if (id_in && !avail_id && (used_count != '0)) begin
          do_rel = 1'b1;
          res_ok = 1'b1;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CNT_W'(POOL_DEPTH);
      used_count <= '0;
      avail      <= '1;
      stack_vld  <= '0;
    end else if (cfg_we) begin
      capacity   <= cfg_wdata;
      used_count <= '0;
      avail      <= '1;
      stack_vld  <= '0;
    end else if (cmd.commit) begin
      if (do_get) begin
        avail[top_id] <= 1'b0;
        used_count    <= used_count + CNT_W'(1);
      end
      if (do_rel) begin
        avail[id_q]         <= 1'b1;
        used_count          <= used_m1;
        stack_vld[rel_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_rel) begin
      stack_mem[rel_addr] <= id_q;
    end
    rd_data <= stack_mem[rd_addr];
    rd_vld  <= stack_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      id_q   <= req_id;
    end
    if (cmd.commit) begin
      granted_id <= res_id;
      ok         <= res_ok;
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idpa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            ok;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  cap;
    logic              typed;
    logic [ID_W-1:0]   granted_id;
    logic              ok;
  } dir_row_t;

  typedef struct packed {
    logic [CNT_W-1:0] cap;
    logic [15:0]      items;
    logic [7:0]       get_pct;
  } pool_phase_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_style_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  idpa_req_if req_ch ();
  idpa_rsp_if rsp_ch ();

  id_pool_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // pool model
  logic [ID_W-1:0]  id_stack [POOL_DEPTH];
  bit               id_free  [POOL_DEPTH];
  logic [CNT_W-1:0] in_use;
  logic [CNT_W-1:0] cap_reg;

  grant_t pending_grants [$];
  event   req_taken;

  logic   typed_en = 1'b0;
  grant_t typed_val = '0;

  rx_style_e rx_style = RX_RANDOM;
  bit        tx_bursty = 1'b1;
  int        burst_left = 0;

  int err_count = 0;
  int n_req = 0, n_rsp = 0, n_grant = 0, n_refused = 0, n_freed = 0, n_caps = 0;
  int stall_cnt = 0;

  dir_row_t dir_tab [29] = '{
    '{ROW_REQ, MODE_CHECK,   8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_CHECK,   8'd255, 9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_RELEASE, 8'd5,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd1, 1'b1},
    '{ROW_REQ, MODE_CHECK,   8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_RELEASE, 8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_RELEASE, 8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b0, 8'd0, 1'b0},
    '{ROW_REQ, MODE_UNUSED,  8'd255, 9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_CAP, MODE_GET,     8'd0,   9'd1,   1'b0, 8'd0, 1'b0},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_CHECK,   8'd1,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_RELEASE, 8'd1,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_RELEASE, 8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_CHECK,   8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_CAP, MODE_GET,     8'd0,   9'd0,   1'b0, 8'd0, 1'b0},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_CHECK,   8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_REQ, MODE_RELEASE, 8'd0,   9'd0,   1'b1, 8'd0, 1'b0},
    '{ROW_CAP, MODE_GET,     8'd0,   9'd511, 1'b0, 8'd0, 1'b0},
    '{ROW_REQ, MODE_CHECK,   8'd255, 9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_GET,     8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_RELEASE, 8'd0,   9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_CAP, MODE_GET,     8'd0,   9'd256, 1'b0, 8'd0, 1'b0},
    '{ROW_REQ, MODE_GET,     8'd255, 9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_CHECK,   8'd170, 9'd0,   1'b1, 8'd0, 1'b1},
    '{ROW_REQ, MODE_RELEASE, 8'd85,  9'd0,   1'b1, 8'd0, 1'b0}
  };

  pool_phase_t phases [10] = '{
    '{9'd1,   16'd40,  8'd45},
    '{9'd2,   16'd40,  8'd50},
    '{9'd0,   16'd20,  8'd40},
    '{9'd511, 16'd60,  8'd50},
    '{9'd256, 16'd300, 8'd95},
    '{9'd5,   16'd60,  8'd45},
    '{9'd37,  16'd80,  8'd50},
    '{9'd300, 16'd40,  8'd50},
    '{9'd128, 16'd80,  8'd55},
    '{9'd255, 16'd30,  8'd50}
  };

  function automatic int pool_size();
    return (cap_reg > POOL_DEPTH) ? POOL_DEPTH : int'(cap_reg);
  endfunction

  function automatic void pool_reinit(input logic [CNT_W-1:0] cap);
    cap_reg = cap;
    in_use  = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      id_stack[i] = ID_W'(i);
      id_free[i]  = 1'b1;
    end
  endfunction

  function automatic grant_t pool_predict(input logic [MODE_W-1:0] m,
                                          input logic [ID_W-1:0] id);
    grant_t r;
    int     lim;
    lim = pool_size();
    r = '0;
    case (m)
      MODE_GET: begin
        if (int'(in_use) < lim) begin
          r.granted_id = id_stack[in_use];
          id_free[r.granted_id] = 1'b0;
          in_use = in_use + 1'b1;
          r.ok = 1'b1;
        end
      end
      MODE_CHECK: begin
        if (int'(id) < lim && id_free[id]) r.ok = 1'b1;
      end
      MODE_RELEASE: begin
        if (int'(id) < lim && !id_free[id] && in_use != 0) begin
          id_free[id] = 1'b1;
          in_use = in_use - 1'b1;
          id_stack[in_use] = id;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit pick_taken(output logic [ID_W-1:0] id);
    int start, idx;
    start = $urandom_range(0, POOL_DEPTH - 1);
    id = '0;
    for (int k = 0; k < POOL_DEPTH; k++) begin
      idx = (start + k) % POOL_DEPTH;
      if (idx < pool_size() && !id_free[idx]) begin
        id = ID_W'(idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic send_req(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                          input logic typed, input grant_t want);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_W'($urandom);
        req_ch.req_id <= ID_W'($urandom);
      end
    end
    if (tx_bursty && burst_left > 0) burst_left--;
    @(negedge clk);
    req_ch.valid  <= 1'b1;
    req_ch.mode   <= m;
    req_ch.req_id <= id;
    typed_en      <= typed;
    typed_val     <= want;
    @(req_taken);
  endtask

  task automatic wait_pool_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    wait_pool_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    pool_reinit(cap);
    n_caps++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // transfer monitor, scoreboard and watchdog
  always @(posedge clk) begin : monitor
    grant_t want, pred;
    bit     moved;
    moved = 1'b0;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      moved = 1'b1;
      n_rsp++;
      if (pending_grants.size() == 0) begin
        $error("unexpected response: granted_id=%0d ok=%0b", rsp_ch.granted_id, rsp_ch.ok);
        err_count++;
      end else begin
        want = pending_grants.pop_front();
        if (rsp_ch.granted_id !== want.granted_id) begin
          $error("granted_id: expected %0d, got %0d", want.granted_id, rsp_ch.granted_id);
          err_count++;
        end
        if (rsp_ch.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, rsp_ch.ok);
          err_count++;
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      moved = 1'b1;
      n_req++;
      pred = pool_predict(req_ch.mode, req_ch.req_id);
      if (req_ch.mode == MODE_GET) begin
        if (pred.ok) n_grant++;
        else n_refused++;
      end else if (req_ch.mode == MODE_RELEASE && pred.ok) begin
        n_freed++;
      end
      pending_grants.push_back(typed_en ? typed_val : pred);
      -> req_taken;
    end
    stall_cnt = moved ? 0 : stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response ready pattern
  int   rx_cnt = 0;
  int   rx_hold = 0;
  logic rx_level = 1'b0;

  always @(negedge clk) begin
    rx_cnt++;
    case (rx_style)
      RX_OPEN:     rsp_ch.ready <= 1'b1;
      RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 9) < 6);
      RX_PERIODIC: rsp_ch.ready <= ((rx_cnt % 8) >= 3);
      default: begin
        if (rx_hold == 0) begin
          rx_hold  = $urandom_range(1, 20);
          rx_level = ~rx_level;
        end
        rx_hold--;
        rsp_ch.ready <= rx_level;
      end
    endcase
  end

  initial begin
    int               r;
    logic [MODE_W-1:0] m;
    logic [ID_W-1:0]   id;
    grant_t            none;
    none = '0;
    req_ch.valid  = 1'b0;
    req_ch.mode   = MODE_GET;
    req_ch.req_id = '0;
    rsp_ch.ready  = 1'b0;
    pool_reinit(9'd256);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CAP) begin
        set_capacity(dir_tab[i].cap);
      end else begin
        send_req(dir_tab[i].mode, dir_tab[i].id, dir_tab[i].typed,
                 '{granted_id: dir_tab[i].granted_id, ok: dir_tab[i].ok});
      end
    end

    foreach (phases[p]) begin
      rx_style  = rx_style_e'(p % 4);
      tx_bursty = (p % 3 != 2);
      set_capacity(phases[p].cap);
      repeat (int'(phases[p].items)) begin
        r  = $urandom_range(0, 99);
        id = ID_W'($urandom);
        if (r < 2) begin
          m = MODE_UNUSED;
        end else if (r < int'(phases[p].get_pct)) begin
          m = MODE_GET;
        end else if ($urandom_range(0, 9) < 6) begin
          m = MODE_RELEASE;
          if ($urandom_range(0, 9) < 8) void'(pick_taken(id));
        end else begin
          m = MODE_CHECK;
          if (pool_size() > 0 && $urandom_range(0, 1) == 0)
            id = ID_W'($urandom_range(0, pool_size() - 1));
        end
        send_req(m, id, 1'b0, none);
      end
    end

    wait_pool_idle();
    repeat (8) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $error("%0d responses never arrived", pending_grants.size());
      err_count++;
    end
    $display("Checked %0d responses to %0d requests over %0d capacity settings.",
             n_rsp, n_req, n_caps);
    $display("Grants %0d, gets refused on an empty pool %0d, IDs taken back %0d.",
             n_grant, n_refused, n_freed);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/idpa_pkg.sv
hdl/idpa_if.sv
hdl/idpa_ctrl.sv
hdl/idpa_dp.sv
hdl/id_pool_allocator.sv
tb/tb.sv
